@@ rtl/bsp_pkg.sv @@
// bsp_pkg: shared types and constants of the billboard sprite projection block
// no dependencies; used by every module under rtl
package bsp_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_CAM_POS_X    = 3'd0;
	localparam logic [2:0] REG_CAM_POS_Y    = 3'd1;
	localparam logic [2:0] REG_VIEW_DIR_X   = 3'd2;
	localparam logic [2:0] REG_VIEW_DIR_Y   = 3'd3;
	localparam logic [2:0] REG_CAM_PLANE_X  = 3'd4;
	localparam logic [2:0] REG_CAM_PLANE_Y  = 3'd5;
	localparam logic [2:0] REG_HOVER_HEIGHT = 3'd6;

	localparam logic [31:0] RST_VIEW_DIR_X  = 32'd65536;
	localparam logic [31:0] RST_CAM_PLANE_Y = 32'd43254;

	// vertical offsets, q16.16
	localparam logic signed [32:0] LEV_FLOAT  = 33'sd22937600;
	localparam logic signed [32:0] LEV_GROUND = 33'sd26214400;

	localparam int PROD_W      = 50;
	localparam int DIV_DW      = 49;
	localparam int DIV_NW      = 64;
	localparam int DIV_CW      = 7;
	localparam int BND_W       = 48;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] plane_x;
		logic signed [31:0] plane_y;
		logic signed [31:0] hover;
	} cfg_t;

	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] lev;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic                start;
		logic [DIV_CW-1:0]   iters;
		logic [DIV_DW-1:0]   divisor;
		logic [DIV_DW-1:0]   rem_init;
		logic [DIV_NW-1:0]   low;
	} div_cmd_t;

	typedef struct packed {
		logic signed [15:0] centre_column;
		logic [14:0]        start_column;
		logic signed [15:0] end_column;
		logic [14:0]        start_row;
		logic signed [15:0] end_row;
		logic [15:0]        sprite_size;
		logic signed [31:0] depth;
		logic               in_front;
		logic               degenerate;
	} res_t;

endpackage

@@ rtl/bsp_front.sv @@
// bsp_front: input side, takes sprite transfers and forms camera-relative items
// depends on bsp_pkg
module bsp_front (
	input  logic             in_valid,
	output logic             in_ready,
	input  logic signed [31:0] sprite_x,
	input  logic signed [31:0] sprite_y,
	input  logic             floating,
	input  bsp_pkg::cfg_t    cfg,
	input  bsp_pkg::q_stat_t q_stat,
	output logic             push,
	output bsp_pkg::item_t   item
);

	logic signed [32:0] hov_e;

	assign in_ready = !q_stat.full;
	assign push     = in_valid && !q_stat.full;
	assign hov_e    = {cfg.hover[31], cfg.hover};

	always_comb begin
		item.dx  = {sprite_x[31], sprite_x} - {cfg.pos_x[31], cfg.pos_x};
		item.dy  = {sprite_y[31], sprite_y} - {cfg.pos_y[31], cfg.pos_y};
		item.lev = floating ? (hov_e + bsp_pkg::LEV_FLOAT) : (bsp_pkg::LEV_GROUND - hov_e);
	end

endmodule

@@ rtl/bsp_fifo.sv @@
// bsp_fifo: short item queue between front and back
// depends on bsp_pkg
module bsp_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bsp_pkg::item_t   wdata,
	input  logic             pop,
	output bsp_pkg::item_t   rdata,
	output bsp_pkg::q_stat_t stat
);

	localparam int AW    = (bsp_pkg::QUEUE_DEPTH > 1) ? $clog2(bsp_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(bsp_pkg::QUEUE_DEPTH + 1);

	bsp_pkg::item_t    mem_q [bsp_pkg::QUEUE_DEPTH];
	logic [AW-1:0]     wr_q;
	logic [AW-1:0]     rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (cnt_q == CNT_W'(bsp_pkg::QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(bsp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(bsp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/bsp_div.sv @@
// bsp_div: restoring divider, one quotient bit a cycle
// depends on bsp_pkg
module bsp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bsp_pkg::div_cmd_t           cmd,
	output logic                        done,
	output logic [bsp_pkg::DIV_NW-1:0]  quot,
	output logic [bsp_pkg::DIV_DW-1:0]  rem
);

	localparam int DW = bsp_pkg::DIV_DW;
	localparam int NW = bsp_pkg::DIV_NW;

	logic [DW-1:0]             rem_q;
	logic [DW-1:0]             d_q;
	logic [NW-1:0]             low_q;
	logic [NW-1:0]             quot_q;
	logic [bsp_pkg::DIV_CW-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [DW:0]               trial;
	logic [DW:0]               diff;
	logic                      ge;

	assign trial = {rem_q, low_q[NW-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = (trial >= {1'b0, d_q});
	assign done  = done_q;
	assign quot  = quot_q;
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// last iteration of a running division
			done_q <= !cmd.start && busy_q && (cnt_q == bsp_pkg::DIV_CW'(1));
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == bsp_pkg::DIV_CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q  <= cmd.rem_init;
			d_q    <= cmd.divisor;
			low_q  <= cmd.low;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			low_q  <= {low_q[NW-2:0], 1'b0};
			quot_q <= {quot_q[NW-2:0], ge};
		end
	end

endmodule

@@ rtl/bsp_back.sv @@
// bsp_back: sequencer for camera transform, divisions and bound clamping
// depends on bsp_pkg and bsp_div
module bsp_back #(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bsp_pkg::cfg_t    cfg,
	input  bsp_pkg::q_stat_t q_stat,
	input  bsp_pkg::item_t   item,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output bsp_pkg::res_t    res
);

	localparam int PW        = bsp_pkg::PROD_W;
	localparam int BW        = bsp_pkg::BND_W;
	localparam int NW        = bsp_pkg::DIV_NW;
	localparam int CW        = bsp_pkg::DIV_CW;
	localparam int HALF_W    = SCREEN_WIDTH / 2;
	localparam int HALF_H    = SCREEN_HEIGHT / 2;
	localparam int CEN_BITS  = $clog2(HALF_W + 1) + 33;
	localparam int SIZE_BITS = $clog2(SCREEN_HEIGHT + 1) + 16;
	localparam logic [NW-1:0] SIZE_LOW =
		(NW'(SCREEN_HEIGHT) * NW'(65536)) << (NW - SIZE_BITS);
	localparam logic signed [BW-1:0] HALF_H_B = BW'(HALF_H);
	localparam logic signed [BW-1:0] W_B      = BW'(SCREEN_WIDTH);
	localparam logic signed [BW-1:0] H_B      = BW'(SCREEN_HEIGHT);
	localparam logic signed [BW-1:0] S15_MAX  = BW'(32767);
	localparam logic signed [BW-1:0] S16_MIN  = BW'(-32768);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MUL  = 8'b0000_0010,
		ST_TX   = 8'b0000_0100,
		ST_TY   = 8'b0000_1000,
		ST_CEN  = 8'b0001_0000,
		ST_SIZE = 8'b0010_0000,
		ST_LEV  = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} st_t;

	st_t                   state_q;
	bsp_pkg::item_t        item_q;
	logic [2:0]            k_q;
	logic [1:0]            ph_q;
	logic [64:0]           acc_q;
	logic signed [PW-1:0]  t_q;
	logic signed [PW-1:0]  det_q;
	logic signed [PW-1:0]  numx_q;
	logic signed [PW-1:0]  numy_q;
	logic signed [31:0]    tx_q;
	logic signed [31:0]    ty_q;
	logic signed [CEN_BITS:0] cen_q;
	logic [SIZE_BITS-1:0]  size_q;
	logic [31:0]           levq_q;
	logic                  levr_nz_q;
	logic                  degen_q;
	logic                  issued_q;
	logic                  out_valid_q;
	bsp_pkg::res_t         res_q;

	bsp_pkg::div_cmd_t     div_cmd;
	logic                  div_done;
	logic [NW-1:0]         div_quot;
	logic [bsp_pkg::DIV_DW-1:0] div_rem;

	bsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	function automatic logic [PW-2:0] mag_p(input logic signed [PW-1:0] v);
		logic [PW-1:0] t;
		t = v[PW-1] ? (~v + PW'(1)) : v;
		return t[PW-2:0];
	endfunction

	function automatic logic signed [31:0] q16_res(input logic ovf, input logic neg,
		input logic [30:0] q);
		logic [31:0] m;
		m = {1'b0, q};
		if (ovf) begin
			return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		return neg ? (~m + 32'd1) : m;
	endfunction

	// truncation fix of (base*ty + lev)/ty from base + trunc(lev/ty)
	function automatic logic signed [BW-1:0] trunc_fix(input logic signed [BW-1:0] y,
		input logic nz, input logic fneg);
		if (nz && fneg && (y > 0)) begin
			return y - BW'(1);
		end
		if (nz && !fneg && (y < 0)) begin
			return y + BW'(1);
		end
		return y;
	endfunction

	function automatic logic [14:0] sat_u15(input logic signed [BW-1:0] v);
		if (v < 0) begin
			return 15'd0;
		end
		if (v > S15_MAX) begin
			return 15'h7fff;
		end
		return v[14:0];
	endfunction

	function automatic logic signed [15:0] clamp_hi(input logic signed [BW-1:0] v,
		input logic signed [BW-1:0] lim);
		logic signed [BW-1:0] c;
		c = (v >= lim) ? (lim - BW'(1)) : v;
		if (c < S16_MIN) begin
			return 16'sh8000;
		end
		return c[15:0];
	endfunction

	// multiplier operand selection
	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	logic [32:0]        ma;
	logic [31:0]        mb;
	logic               mneg;
	logic [48:0]        part;
	logic [48:0]        p_mag;
	logic signed [PW-1:0] p_s;
	logic signed [PW-1:0] p_diff;

	always_comb begin
		case (k_q)
			3'd0:    begin mul_a = {cfg.plane_x[31], cfg.plane_x}; mul_b = cfg.dir_y;   end
			3'd1:    begin mul_a = {cfg.dir_x[31], cfg.dir_x};     mul_b = cfg.plane_y; end
			3'd2:    begin mul_a = item_q.dx;                      mul_b = cfg.dir_y;   end
			3'd3:    begin mul_a = item_q.dy;                      mul_b = cfg.dir_x;   end
			3'd4:    begin mul_a = item_q.dy;                      mul_b = cfg.plane_x; end
			3'd5:    begin mul_a = item_q.dx;                      mul_b = cfg.plane_y; end
			default: begin mul_a = '0;                             mul_b = '0;          end
		endcase
	end

	assign ma     = mul_a[32] ? (~mul_a + 33'd1) : mul_a;
	assign mb     = mul_b[31] ? (~mul_b + 32'd1) : mul_b;
	assign mneg   = mul_a[32] ^ mul_b[31];
	assign part   = {16'b0, ma} * {33'b0, (ph_q == 2'd1) ? mb[31:16] : mb[15:0]};
	assign p_mag  = acc_q[64:16];
	assign p_s    = mneg ? (PW'(0) - {1'b0, p_mag}) : {1'b0, p_mag};
	assign p_diff = t_q - p_s;

	// division operands
	logic [PW-2:0] det_mag;
	logic [PW-2:0] numx_mag;
	logic [PW-2:0] numy_mag;
	logic          tx_ovf;
	logic          ty_ovf;
	logic          tx_neg;
	logic          ty_neg;
	logic signed [32:0] sum;
	logic [32:0]   sum_mag;
	logic [CEN_BITS-1:0] cen_mag;
	logic [31:0]   ty_mag;
	logic [31:0]   lev_mag;
	logic [32:0]   lev_abs;
	logic [CEN_BITS:0] cen_q_mag;

	assign det_mag  = mag_p(det_q);
	assign numx_mag = mag_p(numx_q);
	assign numy_mag = mag_p(numy_q);
	assign tx_ovf   = ({15'b0, numx_mag} >= {det_mag, 15'b0});
	assign ty_ovf   = ({15'b0, numy_mag} >= {det_mag, 15'b0});
	assign tx_neg   = numx_q[PW-1] ^ det_q[PW-1];
	assign ty_neg   = numy_q[PW-1] ^ det_q[PW-1];
	assign sum      = {tx_q[31], tx_q} + {ty_q[31], ty_q};
	assign sum_mag  = sum[32] ? (~sum + 33'd1) : sum;
	assign cen_mag  = CEN_BITS'({{(CEN_BITS - 33){1'b0}}, sum_mag} * CEN_BITS'(HALF_W));
	assign ty_mag   = ty_q[31] ? (~ty_q + 32'd1) : ty_q;
	assign lev_abs  = item_q.lev[32] ? (~item_q.lev + 33'd1) : item_q.lev;
	assign lev_mag  = lev_abs[31:0];
	assign cen_q_mag = {1'b0, div_quot[CEN_BITS-1:0]};

	always_comb begin
		div_cmd = '0;
		case (state_q)
			ST_TX: begin
				div_cmd.start    = !issued_q && (det_q != '0) && !tx_ovf;
				div_cmd.iters    = CW'(31);
				div_cmd.divisor  = det_mag;
				div_cmd.rem_init = numx_mag >> 15;
				div_cmd.low      = {numx_mag[14:0], 49'b0};
			end
			ST_TY: begin
				div_cmd.start    = !issued_q && !ty_ovf;
				div_cmd.iters    = CW'(31);
				div_cmd.divisor  = det_mag;
				div_cmd.rem_init = numy_mag >> 15;
				div_cmd.low      = {numy_mag[14:0], 49'b0};
			end
			ST_CEN: begin
				div_cmd.start   = !issued_q;
				div_cmd.iters   = CW'(CEN_BITS);
				div_cmd.divisor = {17'b0, ty_mag};
				div_cmd.low     = NW'(cen_mag) << (NW - CEN_BITS);
			end
			ST_SIZE: begin
				div_cmd.start   = !issued_q;
				div_cmd.iters   = CW'(SIZE_BITS);
				div_cmd.divisor = {17'b0, ty_mag};
				div_cmd.low     = SIZE_LOW;
			end
			ST_LEV: begin
				div_cmd.start   = !issued_q;
				div_cmd.iters   = CW'(32);
				div_cmd.divisor = {17'b0, ty_mag};
				div_cmd.low     = {lev_mag, 32'b0};
			end
			default: div_cmd = '0;
		endcase
	end

	// bound arithmetic for the final step
	logic signed [BW-1:0] half_b;
	logic signed [BW-1:0] cen_b;
	logic signed [BW-1:0] levq_b;
	logic                 fneg;
	logic signed [BW-1:0] srow;
	logic signed [BW-1:0] erow;
	logic signed [BW-1:0] scol;
	logic signed [BW-1:0] ecol;
	bsp_pkg::res_t        res_d;

	assign half_b = BW'(size_q >> 1);
	assign cen_b  = BW'(cen_q);
	assign fneg   = item_q.lev[32] ^ ty_q[31];
	assign levq_b = fneg ? (BW'(0) - BW'(levq_q)) : BW'(levq_q);
	assign srow   = trunc_fix(HALF_H_B - half_b + levq_b, levr_nz_q, fneg);
	assign erow   = trunc_fix(HALF_H_B + half_b + levq_b, levr_nz_q, fneg);
	assign scol   = cen_b - half_b;
	assign ecol   = cen_b + half_b;

	always_comb begin
		res_d = '0;
		if (degen_q) begin
			res_d.degenerate = 1'b1;
		end else begin
			if (cen_b > S15_MAX) begin
				res_d.centre_column = 16'sh7fff;
			end else if (cen_b < S16_MIN) begin
				res_d.centre_column = 16'sh8000;
			end else begin
				res_d.centre_column = cen_b[15:0];
			end
			res_d.start_column = sat_u15(scol);
			res_d.end_column   = clamp_hi(ecol, W_B);
			res_d.start_row    = sat_u15(srow);
			res_d.end_row      = clamp_hi(erow, H_B);
			res_d.sprite_size  = (size_q > SIZE_BITS'(65535)) ? 16'hffff : size_q[15:0];
			res_d.depth        = ty_q;
			res_d.in_front     = !ty_q[31] && (ty_q != '0);
		end
	end

	assign pop       = (state_q == ST_IDLE) && !q_stat.empty;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			ph_q        <= '0;
			issued_q    <= 1'b0;
			degen_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						k_q     <= '0;
						ph_q    <= '0;
						degen_q <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						if (k_q == 3'd5) begin
							state_q <= ST_TX;
						end else begin
							k_q <= k_q + 3'd1;
						end
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				ST_TX: begin
					if (!issued_q) begin
						if (det_q == '0) begin
							degen_q <= 1'b1;
							state_q <= ST_FIN;
						end else if (tx_ovf) begin
							state_q <= ST_TY;
						end else begin
							issued_q <= 1'b1;
						end
					end else if (div_done) begin
						issued_q <= 1'b0;
						state_q  <= ST_TY;
					end
				end
				ST_TY: begin
					if (!issued_q) begin
						if (ty_ovf) begin
							state_q <= ST_CEN;
						end else begin
							issued_q <= 1'b1;
						end
					end else if (div_done) begin
						issued_q <= 1'b0;
						if (div_quot[30:0] == '0) begin
							degen_q <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_CEN;
						end
					end
				end
				ST_CEN: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
					end else if (div_done) begin
						issued_q <= 1'b0;
						state_q  <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
					end else if (div_done) begin
						issued_q <= 1'b0;
						state_q  <= ST_LEV;
					end
				end
				ST_LEV: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
					end else if (div_done) begin
						issued_q <= 1'b0;
						state_q  <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					item_q <= item;
				end
			end
			ST_MUL: begin
				case (ph_q)
					2'd0:    acc_q <= {16'b0, part};
					2'd1:    acc_q <= acc_q + {part, 16'b0};
					default: begin
						if (!k_q[0]) begin
							t_q <= p_s;
						end else if (k_q == 3'd1) begin
							det_q <= p_diff;
						end else if (k_q == 3'd3) begin
							numx_q <= p_diff;
						end else begin
							numy_q <= p_diff;
						end
					end
				endcase
			end
			ST_TX: begin
				if (!issued_q && tx_ovf) begin
					tx_q <= q16_res(1'b1, tx_neg, '0);
				end else if (issued_q && div_done) begin
					tx_q <= q16_res(1'b0, tx_neg, div_quot[30:0]);
				end
			end
			ST_TY: begin
				if (!issued_q && ty_ovf) begin
					ty_q <= q16_res(1'b1, ty_neg, '0);
				end else if (issued_q && div_done) begin
					ty_q <= q16_res(1'b0, ty_neg, div_quot[30:0]);
				end
			end
			ST_CEN: begin
				if (issued_q && div_done) begin
					cen_q <= (sum[32] ^ ty_q[31]) ? ((CEN_BITS + 1)'(0) - cen_q_mag) : cen_q_mag;
				end
			end
			ST_SIZE: begin
				if (issued_q && div_done) begin
					size_q <= div_quot[SIZE_BITS-1:0];
				end
			end
			ST_LEV: begin
				if (issued_q && div_done) begin
					levq_q    <= div_quot[31:0];
					levr_nz_q <= (div_rem != '0);
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					res_q <= res_d;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/billboard_sprite_projection.sv @@
// billboard_sprite_projection: top level, configuration registers and the front/queue/back chain
// depends on bsp_pkg, bsp_front, bsp_fifo, bsp_back (and bsp_div below it)

// Projects one sprite world position (q16.16) to screen space for a raycaster view.
// A sprite transfer is taken whenever the two-entry queue has room, so the next
// sprites are accepted while earlier ones are still being worked on and while a
// finished result waits in the output register. The back end runs the six camera
// products through one 33x16 multiplier, each as a low-half partial product, a
// high-half partial product added in and a signed store of the result, then uses
// the single shared divider, which yields one quotient bit per cycle, up to five
// times per sprite (two q16.16 quotients, centre column, size and vertical offset).
// A q16.16 quotient that saturates skips its division, a degenerate sprite goes
// straight to the result, and a finished result that is not taken holds the back end.
// Configuration is to be written only while the block is idle; the block itself
// does not enforce this. Out-of-range indexes are dropped.
module billboard_sprite_projection #(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// sprite input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] sprite_x,
	input  logic signed [31:0] sprite_y,
	input  logic               floating,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] centre_column,
	output logic [14:0]        start_column,
	output logic signed [15:0] end_column,
	output logic [14:0]        start_row,
	output logic signed [15:0] end_row,
	output logic [15:0]        sprite_size,
	output logic signed [31:0] depth,
	output logic               in_front,
	output logic               degenerate
);

	bsp_pkg::cfg_t    cfg_q;
	bsp_pkg::q_stat_t q_stat;
	bsp_pkg::item_t   push_item;
	bsp_pkg::item_t   pop_item;
	bsp_pkg::res_t    res;
	logic             push;
	logic             pop;

	// camera registers, reset to a unit view along +x with a 0.66 plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{pos_x: '0, pos_y: '0, dir_x: bsp_pkg::RST_VIEW_DIR_X, dir_y: '0,
				plane_x: '0, plane_y: bsp_pkg::RST_CAM_PLANE_Y, hover: '0};
		end else if (cfg_we) begin
			case (cfg_index)
				bsp_pkg::REG_CAM_POS_X:    cfg_q.pos_x   <= cfg_data;
				bsp_pkg::REG_CAM_POS_Y:    cfg_q.pos_y   <= cfg_data;
				bsp_pkg::REG_VIEW_DIR_X:   cfg_q.dir_x   <= cfg_data;
				bsp_pkg::REG_VIEW_DIR_Y:   cfg_q.dir_y   <= cfg_data;
				bsp_pkg::REG_CAM_PLANE_X:  cfg_q.plane_x <= cfg_data;
				bsp_pkg::REG_CAM_PLANE_Y:  cfg_q.plane_y <= cfg_data;
				bsp_pkg::REG_HOVER_HEIGHT: cfg_q.hover   <= cfg_data;
				default:                   cfg_q         <= cfg_q;
			endcase
		end
	end

	// front: camera-relative offsets and vertical offset per transfer
	bsp_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sprite_x (sprite_x),
		.sprite_y (sprite_y),
		.floating (floating),
		.cfg      (cfg_q),
		.q_stat   (q_stat),
		.push     (push),
		.item     (push_item)
	);

	// queue decouples acceptance from the long back-end sequence
	bsp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_item),
		.pop    (pop),
		.rdata  (pop_item),
		.stat   (q_stat)
	);

	// back: transform, divisions, clamping, output register
	bsp_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.item      (pop_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign centre_column = res.centre_column;
	assign start_column  = res.start_column;
	assign end_column    = res.end_column;
	assign start_row     = res.start_row;
	assign end_row       = res.end_row;
	assign sprite_size   = res.sprite_size;
	assign depth         = res.depth;
	assign in_front      = res.in_front;
	assign degenerate    = res.degenerate;

	// in-front flag must agree with the sign of the depth
	a_front_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (in_front == (!depth[31] && (depth != 32'sd0))))
		else $error("in_front disagrees with depth");

	// upper bounds are clamped to the screen
	a_bound_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (($signed(end_column) <= SCREEN_WIDTH - 1) &&
			($signed(end_row) <= SCREEN_HEIGHT - 1)))
		else $error("end bound beyond screen");

	// a degenerate result carries no geometry
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |-> ((depth == 32'sd0) && (sprite_size == 16'd0) &&
			!in_front && (centre_column == 16'sd0)))
		else $error("degenerate result with non-zero fields");

endmodule

@@ bench/tb_billboard_sprite_projection.sv @@
// tb_billboard_sprite_projection: self-checking bench for the sprite projection block
// depends on bsp_pkg and the rtl under rtl; a scoreboard class predicts every result
module tb_billboard_sprite_projection;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = 640;
	localparam int SH = 480;
	localparam int N_REGS = 7;
	localparam logic [2:0] REG_NONE = 3'd7; // index past the register file

	// expected-result store with its own copy of the camera registers
	class projection_board;
		int cam_reg [N_REGS];
		bsp_pkg::res_t pending_q [$];
		int mismatches;
		int results_seen;
		int degenerate_seen;
		int behind_seen;

		function new();
			cam_reg = '{0, 0, 65536, 0, 0, 43254, 0};
			mismatches = 0;
			results_seen = 0;
			degenerate_seen = 0;
			behind_seen = 0;
		endfunction

		function longint unsigned magnitude(longint a);
			return a < 0 ? longint'(0) - a : a;
		endfunction

		// q16.16 product, truncated toward zero
		function longint mul_q(longint a, longint b);
			longint unsigned p;
			p = (magnitude(a) * magnitude(b)) >> 16;
			return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
		endfunction

		// q16.16 quotient, truncated toward zero, saturated to 32 bits
		function longint div_q(longint n, longint d);
			longint unsigned un, ud, q0, m;
			logic neg;
			un = magnitude(n);
			ud = magnitude(d);
			q0 = un / ud;
			neg = (n < 0) != (d < 0);
			if (q0 >= 32768)
				return neg ? -64'sd2147483648 : 64'sd2147483647;
			m = (q0 << 16) | (((un % ud) << 16) / ud);
			return neg ? -longint'(m) : longint'(m);
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		// work out the projection of one accepted sprite
		function void note_sprite(int sx, int sy, logic fl);
			longint dx, dy, det, numx, numy, tx, ty, centre, size, half, lev;
			longint base, srow, erow, scol, ecol;
			bsp_pkg::res_t e;
			e = '0;
			dx = longint'(sx) - longint'(cam_reg[bsp_pkg::REG_CAM_POS_X]);
			dy = longint'(sy) - longint'(cam_reg[bsp_pkg::REG_CAM_POS_Y]);
			det = mul_q(cam_reg[bsp_pkg::REG_CAM_PLANE_X], cam_reg[bsp_pkg::REG_VIEW_DIR_Y])
				- mul_q(cam_reg[bsp_pkg::REG_VIEW_DIR_X], cam_reg[bsp_pkg::REG_CAM_PLANE_Y]);
			if (det == 0) begin
				e.degenerate = 1'b1;
				pending_q.push_back(e);
				return;
			end
			numx = mul_q(cam_reg[bsp_pkg::REG_VIEW_DIR_Y], dx)
				- mul_q(cam_reg[bsp_pkg::REG_VIEW_DIR_X], dy);
			numy = mul_q(cam_reg[bsp_pkg::REG_CAM_PLANE_X], dy)
				- mul_q(cam_reg[bsp_pkg::REG_CAM_PLANE_Y], dx);
			tx = div_q(numx, det);
			ty = div_q(numy, det);
			if (ty == 0) begin
				e.degenerate = 1'b1;
				pending_q.push_back(e);
				return;
			end
			centre = (longint'(SW / 2) * (ty + tx)) / ty;
			size = (longint'(SH) * 65536) / ty;
			if (size < 0)
				size = -size;
			half = size / 2;
			lev = fl ? longint'(cam_reg[bsp_pkg::REG_HOVER_HEIGHT]) + (longint'(350) << 16)
				: (longint'(400) << 16) - longint'(cam_reg[bsp_pkg::REG_HOVER_HEIGHT]);
			base = SH / 2 - half;
			srow = (base * ty + lev) / ty;
			if (srow < 0)
				srow = 0;
			base = SH / 2 + half;
			erow = (base * ty + lev) / ty;
			if (erow >= SH)
				erow = SH - 1;
			scol = centre - half;
			if (scol < 0)
				scol = 0;
			ecol = centre + half;
			if (ecol >= SW)
				ecol = SW - 1;
			e.centre_column = 16'(clip(centre, -32768, 32767));
			e.start_column = 15'(clip(scol, 0, 32767));
			e.end_column = 16'(clip(ecol, -32768, 32767));
			e.start_row = 15'(clip(srow, 0, 32767));
			e.end_row = 16'(clip(erow, -32768, 32767));
			e.sprite_size = 16'(clip(size, 0, 65535));
			e.depth = ty[31:0];
			e.in_front = ty > 0;
			pending_q.push_back(e);
		endfunction

		function void fail_line(string what, longint exp_v, longint got_v);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
		endfunction

		// compare one result transfer with the oldest expectation
		function void check_result(bsp_pkg::res_t got);
			bsp_pkg::res_t e;
			results_seen++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer at %0t", $realtime);
				return;
			end
			e = pending_q.pop_front();
			if (e.degenerate)
				degenerate_seen++;
			else if (!e.in_front)
				behind_seen++;
			if (got.centre_column !== e.centre_column)
				fail_line("centre_column", e.centre_column, got.centre_column);
			if (got.start_column !== e.start_column)
				fail_line("start_column", e.start_column, got.start_column);
			if (got.end_column !== e.end_column)
				fail_line("end_column", e.end_column, got.end_column);
			if (got.start_row !== e.start_row)
				fail_line("start_row", e.start_row, got.start_row);
			if (got.end_row !== e.end_row)
				fail_line("end_row", e.end_row, got.end_row);
			if (got.sprite_size !== e.sprite_size)
				fail_line("sprite_size", e.sprite_size, got.sprite_size);
			if (got.depth !== e.depth)
				fail_line("depth", e.depth, got.depth);
			if (got.in_front !== e.in_front)
				fail_line("in_front", e.in_front, got.in_front);
			if (got.degenerate !== e.degenerate)
				fail_line("degenerate", e.degenerate, got.degenerate);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] sprite_x = '0;
	logic signed [31:0] sprite_y = '0;
	logic floating = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] centre_column;
	logic [14:0] start_column;
	logic signed [15:0] end_column;
	logic [14:0] start_row;
	logic signed [15:0] end_row;
	logic [15:0] sprite_size;
	logic signed [31:0] depth;
	logic in_front;
	logic degenerate;
	bsp_pkg::res_t got;

	// idling switches for each side; quiet phases turn them off
	logic tx_quiet = 1'b0;
	logic rx_quiet = 1'b0;
	int sprites_sent = 0;
	projection_board board;

	billboard_sprite_projection #(.SCREEN_WIDTH(SW), .SCREEN_HEIGHT(SH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.sprite_x(sprite_x), .sprite_y(sprite_y), .floating(floating),
		.out_valid(out_valid), .out_ready(out_ready),
		.centre_column(centre_column), .start_column(start_column),
		.end_column(end_column), .start_row(start_row), .end_row(end_row),
		.sprite_size(sprite_size), .depth(depth),
		.in_front(in_front), .degenerate(degenerate)
	);

	// result fields gathered in struct order
	assign got = {centre_column, start_column, end_column, start_row, end_row,
		sprite_size, depth, in_front, degenerate};

	always #5 clk = ~clk;

	// receiver stalls at random, changed on the falling edge
	always @(negedge clk) begin
		out_ready <= rx_quiet ? 1'b1 : ($urandom_range(0, 99) >= 9);
	end

	// result transfers are taken at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(got);
	end

	// register write, only ever issued with nothing in flight
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx < N_REGS)
			board.cam_reg[idx] = val;
	endtask

	// let everything drain before touching the registers
	task automatic drain();
		in_valid = 1'b0;
		while (board.pending_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// one sprite transfer; valid stays high until taken
	task automatic send_sprite(logic [31:0] sx, logic [31:0] sy, logic fl);
		while (!tx_quiet && $urandom_range(0, 99) < 9) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		sprite_x = sx;
		sprite_y = sy;
		floating = fl;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_sprite(sx, sy, fl);
		sprites_sent++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] corner_value();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'h1;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	function automatic logic [31:0] near(int centre_v, int span);
		return centre_v + $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	// register settings per phase: sane camera, fully random, corners, flat matrix
	task automatic set_camera(int mode);
		logic [31:0] v [N_REGS];
		for (int k = 0; k < N_REGS; k++)
			v[k] = $urandom();
		case (mode)
			0: begin
				v[bsp_pkg::REG_CAM_POS_X] = near(0, 1 << 22);
				v[bsp_pkg::REG_CAM_POS_Y] = near(0, 1 << 22);
				v[bsp_pkg::REG_VIEW_DIR_X] = near(0, 1 << 17);
				v[bsp_pkg::REG_VIEW_DIR_Y] = near(0, 1 << 17);
				v[bsp_pkg::REG_CAM_PLANE_X] = near(0, 1 << 17);
				v[bsp_pkg::REG_CAM_PLANE_Y] = near(0, 1 << 17);
				v[bsp_pkg::REG_HOVER_HEIGHT] = near(0, 1 << 25);
			end
			2: begin
				for (int k = 0; k < N_REGS; k++)
					v[k] = corner_value();
			end
			3: begin
				// plane parallel to the view direction: zero determinant
				v[bsp_pkg::REG_VIEW_DIR_X] = near(0, 1 << 16);
				v[bsp_pkg::REG_VIEW_DIR_Y] = near(0, 1 << 16);
				v[bsp_pkg::REG_CAM_PLANE_X] = v[bsp_pkg::REG_VIEW_DIR_X];
				v[bsp_pkg::REG_CAM_PLANE_Y] = v[bsp_pkg::REG_VIEW_DIR_Y];
			end
			default: ;
		endcase
		for (int k = 0; k < N_REGS; k++)
			write_reg(k[2:0], v[k]);
	endtask

	task automatic random_sprite(int mode);
		int px, py;
		px = board.cam_reg[bsp_pkg::REG_CAM_POS_X];
		py = board.cam_reg[bsp_pkg::REG_CAM_POS_Y];
		case ($urandom_range(0, 9))
			0, 1: send_sprite($urandom(), $urandom(), 1'($urandom_range(0, 1)));
			2: send_sprite(px, py, 1'($urandom_range(0, 1)));
			3: send_sprite(corner_value(), corner_value(), 1'($urandom_range(0, 1)));
			default:
				send_sprite(near(px, mode == 0 ? 1 << 21 : 1 << 18),
					near(py, mode == 0 ? 1 << 21 : 1 << 18), 1'($urandom_range(0, 1)));
		endcase
	endtask

	initial begin
		int mode;
		board = new();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part with reset registers: ahead, behind, at the camera, extremes
		tx_quiet = 1'b1;
		send_sprite(32'd5 << 16, 32'd0, 1'b0);
		send_sprite(32'd5 << 16, 32'd0, 1'b1);
		send_sprite(32'd3 << 16, 32'd1 << 16, 1'b0);
		send_sprite(-(32'd4 << 16), 32'd2 << 16, 1'b1);
		send_sprite(32'd0, 32'd0, 1'b0);
		send_sprite(32'd0, 32'd7 << 16, 1'b1);
		send_sprite(32'd1, 32'd0, 1'b0);
		send_sprite(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
		send_sprite(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_sprite(32'h7fff_ffff, 32'h8000_0000, 1'b1);
		send_sprite(32'h8000_0000, 32'h0, 1'b0);
		send_sprite(32'd100 << 16, -(32'd300 << 16), 1'b0);
		tx_quiet = 1'b0;

		// pause the sender until every expected result is back
		drain();
		write_reg(REG_NONE, 32'hdead_beef); // out-of-range index is dropped
		write_reg(bsp_pkg::REG_HOVER_HEIGHT, 32'd50 << 16);
		send_sprite(32'd2 << 16, 32'd0, 1'b1);
		send_sprite(32'd2 << 16, 32'd0, 1'b0);
		drain();
		set_camera(2);
		for (int k = 0; k < 6; k++)
			send_sprite(corner_value(), corner_value(), k[0]);
		drain();
		set_camera(3);
		send_sprite(32'd3 << 16, 32'd1 << 16, 1'b0);
		send_sprite(32'h7fff_ffff, 32'h8000_0000, 1'b1);

		// random phases; phase 4 runs with no idling on either side
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			mode = (ph == 2 || ph == 6) ? 1 : (ph == 5) ? 2 : (ph == 7) ? 3 : 0;
			set_camera(mode);
			tx_quiet = (ph == 4);
			rx_quiet = (ph == 4);
			for (int n = 0; n < 225; n++)
				random_sprite(mode);
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		in_valid = 1'b0;
		while (board.pending_q.size() != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
		$display("%0d sprites projected over twelve register settings: %0d degenerate, %0d behind",
			sprites_sent, board.degenerate_seen, board.behind_seen);
		$display("%0d result transfers checked, %0d mismatches", board.results_seen,
			board.mismatches);
		if (board.mismatches == 0 && board.pending_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#(30_000_000);
		$display("timeout with %0d results outstanding", board.pending_q.size());
		$display("simulation failed");
		$finish;
	end

endmodule
